FILE: src/tami_pkg.sv
// Shared types and constants for the tetrahedron inverse-map block.
`timescale 1ns / 1ps
package tami_pkg;

    localparam int CoordW = 24;            // Q8.16 vertex coordinate
    localparam int MW     = CoordW + 1;    // edge vector entry
    localparam int CofW   = 2 * MW + 1;    // cofactor
    localparam int CofLoW = 26;            // low slice of a cofactor for the split product
    localparam int DetW   = 76;            // exact determinant, units of 2^-51
    localparam int JacW   = 49;            // Q24.24 Jacobian
    localparam int JacLsb = DetW - JacW;   // determinant bit that is the Jacobian LSB
    localparam int EntW   = 32;            // Q16.16 inverse entry
    localparam int QW     = EntW + 1;      // quotient bits, top bit flags overflow
    localparam int RemW   = CofW + QW;     // scaled cofactor magnitude
    localparam int CmpW   = DetW + EntW;   // divisor at its largest shift
    localparam int NDim   = 3;
    localparam int NEnt   = NDim * NDim;
    localparam int RowW   = 2;

    localparam logic [RowW-1:0] Row0    = 2'd0;
    localparam logic [RowW-1:0] Row1    = 2'd1;
    localparam logic [RowW-1:0] Row2    = 2'd2;
    localparam logic [RowW-1:0] RowLast = Row2;

    localparam logic [EntW-1:0] EntMaxPos = 32'h7FFF_FFFF;
    localparam logic [EntW-1:0] EntMaxNeg = 32'h8000_0000;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [MW-1:0]     t_m;
    typedef logic signed [CofW-1:0]   t_cof;
    typedef logic signed [DetW-1:0]   t_det;
    typedef logic signed [JacW-1:0]   t_jac;
    typedef logic signed [EntW-1:0]   t_ent;

    // One tetrahedron after the front end: cofactors (row-major) and determinant.
    typedef struct packed {
        t_cof [NEnt-1:0] cof;
        t_det            det;
    } t_rec;

endpackage

FILE: src/tami_ifs.sv
// Channel interfaces: vertex item in, inverse row out.
`timescale 1ns / 1ps
interface tami_item_if import tami_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord v0_x, v0_y, v0_z;
    t_coord v1_x, v1_y, v1_z;
    t_coord v2_x, v2_y, v2_z;
    t_coord v3_x, v3_y, v3_z;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, input ready);
    modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, output ready);
endinterface

interface tami_row_if import tami_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [RowW-1:0] row_index;
    t_ent            inv_c0, inv_c1, inv_c2;
    t_jac            jacobian;
    logic            singular;
    logic            last;

    modport source (output valid, row_index, inv_c0, inv_c1, inv_c2, jacobian,
                    singular, last, input ready);
    modport sink   (input valid, row_index, inv_c0, inv_c1, inv_c2, jacobian,
                    singular, last, output ready);
endinterface

FILE: src/tetra_affine_map_inverse.sv
// Top level: inverse affine reference map of a linear tetrahedron.
`timescale 1ns / 1ps
// Takes one tetrahedron (four Q8.16 vertices) per input transaction and returns three
// output transactions, rows 0, 1 and 2 of the inverse reference map (adjugate over the
// determinant, Q16.16, saturated), each with the Q24.24 Jacobian, a singular flag
// (zero determinant, entries then zero) and last on row 2. The front end computes
// edge vectors, cofactors and the determinant in a pipeline that takes an item every
// cycle unless the queue is full; a QDepth-entry queue decouples it from the back end.
// The back end feeds one row per cycle, unless the output stalls, into a single
// 33-stage restoring divider pipeline (one quotient bit per stage, three lanes) and
// takes the next tetrahedron as row 2 issues, with earlier rows still in it. Output
// backpressure stalls the back end; the input keeps accepting until the queue fills.
module tetra_affine_map_inverse import tami_pkg::*; #(
    parameter int QDepth = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tami_item_if.sink   i_item,
    tami_row_if.source  o_row
);

    logic w_f_vld, w_f_rdy;
    t_rec w_f_rec;
    logic w_q_vld, w_q_rdy;
    t_rec w_q_rec;

    tami_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_vld   (w_f_vld),
        .o_rec   (w_f_rec),
        .i_rdy   (w_f_rdy)
    );

    tami_queue #(.QDepth(QDepth)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (w_f_vld),
        .i_push_rec (w_f_rec),
        .o_push_rdy (w_f_rdy),
        .o_pop_vld  (w_q_vld),
        .o_pop_rec  (w_q_rec),
        .i_pop_rdy  (w_q_rdy)
    );

    tami_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_q_vld),
        .i_rec   (w_q_rec),
        .o_rdy   (w_q_rdy),
        .o_row   (o_row)
    );

    // last marks exactly the final row of a run
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid |-> (o_row.last == (o_row.row_index == RowLast)))
        else $error("last flag does not match row index");

    // singular map gives zero entries and zero Jacobian
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid && o_row.singular |->
            (o_row.inv_c0 == '0 && o_row.inv_c1 == '0 && o_row.inv_c2 == '0 &&
             o_row.jacobian == '0))
        else $error("singular row carries nonzero data");

    // rows of a run come out in order
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid && o_row.ready && !o_row.last |=>
            (!o_row.valid || o_row.row_index == RowW'($past(o_row.row_index) + 1'b1)))
        else $error("row sequence broken");

endmodule

FILE: src/tami_front.sv
// Front end: edge vectors, cofactors and determinant, four pipeline stages.
`timescale 1ns / 1ps
module tami_front import tami_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tami_item_if.sink   i_item,
    output logic        o_vld,
    output t_rec        o_rec,
    input  logic        i_rdy
);

    typedef logic signed [MW+CofLoW:0]      t_plo;
    typedef logic signed [MW+CofW-CofLoW-1:0] t_phi;

    logic [3:0]      r_vld;
    logic            w_en;
    t_coord [11:0]   w_v;
    t_m [NEnt-1:0]   n_m, r_m;
    t_cof [NEnt-1:0] n_cof, r_cof_b, r_cof_c;
    t_m [NDim-1:0]   r_m0_b;
    t_plo [NDim-1:0] n_plo, r_plo;
    t_phi [NDim-1:0] n_phi, r_phi;
    t_det            n_det;
    t_rec            r_rec;

    assign w_en         = !r_vld[3] || i_rdy;
    assign i_item.ready = w_en;
    assign o_vld        = r_vld[3];
    assign o_rec        = r_rec;

    // vertex-major, axis-minor
    assign w_v = {i_item.v3_z, i_item.v3_y, i_item.v3_x, i_item.v2_z, i_item.v2_y, i_item.v2_x,
                  i_item.v1_z, i_item.v1_y, i_item.v1_x, i_item.v0_z, i_item.v0_y, i_item.v0_x};

    always_comb begin
        for (int r = 0; r < NDim; r++) begin
            for (int c = 0; c < NDim; c++) begin
                n_m[r*NDim+c] = MW'($signed(w_v[(c+1)*NDim+r])) - MW'($signed(w_v[r]));
            end
        end
    end

    always_comb begin
        logic signed [2*MW-1:0] p1;
        logic signed [2*MW-1:0] p2;
        int r1, r2, c1, c2;
        for (int r = 0; r < NDim; r++) begin
            for (int c = 0; c < NDim; c++) begin
                r1 = (r == NDim-1) ? 0 : r + 1;
                r2 = (r == 0) ? NDim-1 : r - 1;
                c1 = (c == NDim-1) ? 0 : c + 1;
                c2 = (c == 0) ? NDim-1 : c - 1;
                p1 = $signed(r_m[r1*NDim+c1]) * $signed(r_m[r2*NDim+c2]);
                p2 = $signed(r_m[r1*NDim+c2]) * $signed(r_m[r2*NDim+c1]);
                n_cof[r*NDim+c] = CofW'(p1) - CofW'(p2);
            end
        end
    end

    // det = sum m0c * cof0c; cofactor split into a signed high and unsigned low part
    always_comb begin
        logic signed [CofLoW:0]        lo;
        logic signed [CofW-CofLoW-1:0] hi;
        for (int c = 0; c < NDim; c++) begin
            lo       = $signed({1'b0, r_cof_b[c][CofLoW-1:0]});
            hi       = $signed(r_cof_b[c][CofW-1:CofLoW]);
            n_plo[c] = $signed(r_m0_b[c]) * lo;
            n_phi[c] = $signed(r_m0_b[c]) * hi;
        end
    end

    always_comb begin
        n_det = '0;
        for (int c = 0; c < NDim; c++) begin
            n_det = n_det + (DetW'($signed(r_phi[c])) <<< CofLoW) + DetW'($signed(r_plo[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[2:0], i_item.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m     <= n_m;
            r_cof_b <= n_cof;
            r_m0_b  <= r_m[NDim-1:0];
            r_plo   <= n_plo;
            r_phi   <= n_phi;
            r_cof_c <= r_cof_b;
            r_rec   <= '{cof: r_cof_c, det: n_det};
        end
    end

endmodule

FILE: src/tami_queue.sv
// Small FIFO between front end and divider back end.
`timescale 1ns / 1ps
module tami_queue import tami_pkg::*; #(
    parameter int QDepth = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_vld,
    input  t_rec i_push_rec,
    output logic o_push_rdy,
    output logic o_pop_vld,
    output t_rec o_pop_rec,
    input  logic i_pop_rdy
);

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);

    t_rec            r_mem [QDepth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_cnt;
    logic            w_push, w_pop;

    assign o_push_rdy = r_cnt != CntW'(QDepth);
    assign o_pop_vld  = r_cnt != '0;
    assign o_pop_rec  = r_mem[r_rd_ptr];
    assign w_push     = i_push_vld && o_push_rdy;
    assign w_pop      = o_pop_vld && i_pop_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QDepth-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QDepth-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

endmodule

FILE: src/tami_back.sv
// Back end: bit-per-stage divider pipeline, one inverse row per cycle unless stalled.
`timescale 1ns / 1ps
module tami_back import tami_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_rec        i_rec,
    output logic        o_rdy,
    tami_row_if.source  o_row
);

    localparam int NStg = QW + 1;

    typedef struct packed {
        logic [RowW-1:0]             row;
        logic                        last;
        logic                        sing;
        t_jac                        jac;
        logic [DetW-1:0]             den;
        logic [NDim-1:0]             neg;
        logic [NDim-1:0][RemW-1:0]   rem;
        logic [NDim-1:0][QW-1:0]     quo;
    } t_dst;

    function automatic t_dst div_step(input t_dst s, input int sh);
        t_dst            o;
        logic [CmpW-1:0] cmp;
        o   = s;
        cmp = CmpW'(s.den) << sh;
        for (int l = 0; l < NDim; l++) begin
            if (CmpW'(s.rem[l]) >= cmp) begin
                o.rem[l]     = s.rem[l] - cmp[RemW-1:0];
                o.quo[l][sh] = 1'b1;
            end
        end
        return o;
    endfunction

    logic              w_en;
    logic [RowW-1:0]   r_row;
    logic [NStg-1:0]   r_vld;
    t_dst              r_st [NStg];
    t_dst              n_st [NStg];
    t_cof [NDim-1:0]   w_cof;
    t_ent [NDim-1:0]   n_ent;
    logic              r_out_vld;
    logic [RowW-1:0]   r_out_row;
    t_ent [NDim-1:0]   r_out_ent;
    t_jac              r_out_jac;
    logic              r_out_sing;
    logic              r_out_last;

    assign w_en  = !r_out_vld || o_row.ready;
    assign o_rdy = w_en && (r_row == RowLast);

    always_comb begin
        case (r_row)
            Row0:    w_cof = i_rec.cof[NDim-1:0];
            Row1:    w_cof = i_rec.cof[2*NDim-1:NDim];
            Row2:    w_cof = i_rec.cof[3*NDim-1:2*NDim];
            default: w_cof = '0;
        endcase
    end

    // issue stage: magnitudes, signs, scaled numerators
    always_comb begin
        logic [CofW-1:0] mag;
        n_st[0].row  = r_row;
        n_st[0].last = r_row == RowLast;
        n_st[0].sing = i_rec.det == '0;
        n_st[0].jac  = i_rec.det[DetW-1:JacLsb];
        n_st[0].den  = i_rec.det[DetW-1] ? DetW'(-i_rec.det) : DetW'(i_rec.det);
        n_st[0].quo  = '0;
        for (int l = 0; l < NDim; l++) begin
            mag              = w_cof[l][CofW-1] ? CofW'(-w_cof[l]) : CofW'(w_cof[l]);
            n_st[0].neg[l]   = w_cof[l][CofW-1] ^ i_rec.det[DetW-1];
            n_st[0].rem[l]   = {mag, {QW{1'b0}}};
        end
        for (int k = 0; k < NStg-1; k++) begin
            n_st[k+1] = div_step(r_st[k], QW-1-k);
        end
    end

    // saturate, apply sign, force zero on a singular map
    always_comb begin
        logic [EntW-1:0] lim;
        logic [EntW-1:0] mag;
        for (int l = 0; l < NDim; l++) begin
            lim = r_st[NStg-1].neg[l] ? EntMaxNeg : EntMaxPos;
            mag = (r_st[NStg-1].quo[l][QW-1] || r_st[NStg-1].quo[l][EntW-1:0] > lim)
                  ? lim : r_st[NStg-1].quo[l][EntW-1:0];
            if (r_st[NStg-1].sing) begin
                n_ent[l] = '0;
            end else begin
                n_ent[l] = r_st[NStg-1].neg[l] ? t_ent'(-mag) : t_ent'(mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= Row0;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            if (i_vld) begin
                r_row <= (r_row == RowLast) ? Row0 : r_row + 1'b1;
            end
            r_vld     <= {r_vld[NStg-2:0], i_vld};
            r_out_vld <= r_vld[NStg-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NStg; k++) begin
                r_st[k] <= n_st[k];
            end
            r_out_row  <= r_st[NStg-1].row;
            r_out_ent  <= n_ent;
            r_out_jac  <= r_st[NStg-1].jac;
            r_out_sing <= r_st[NStg-1].sing;
            r_out_last <= r_st[NStg-1].last;
        end
    end

    assign o_row.valid     = r_out_vld;
    assign o_row.row_index = r_out_row;
    assign o_row.inv_c0    = r_out_ent[0];
    assign o_row.inv_c1    = r_out_ent[1];
    assign o_row.inv_c2    = r_out_ent[2];
    assign o_row.jacobian  = r_out_jac;
    assign o_row.singular  = r_out_sing;
    assign o_row.last      = r_out_last;

endmodule

FILE: tb/sv/testbench.sv
// Testbench for the tetrahedron inverse-map block: scoreboard, drivers and checks.
`timescale 1ns / 1ps
module testbench import tami_pkg::*; ();

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] c0, c1, c2;
        logic signed [48:0] jac;
        logic               sing, last;
    } t_row_exp;

    // Scoreboard: computes expected inverse rows from each accepted tetrahedron.
    class inverse_board;
        t_row_exp rows_q[$];
        int       errors;
        int       n_rows;
        int       n_sing;
        int       n_sat;

        function new();
            errors = 0;
            n_rows = 0;
            n_sing = 0;
            n_sat  = 0;
        endfunction

        // (cof * 2^33) / det, toward zero, saturated to 32 bits
        function logic signed [31:0] entry(logic signed [127:0] cof,
                                           logic signed [127:0] det);
            logic signed [127:0] num;
            logic signed [127:0] q;
            num = cof <<< 33;
            q   = num / det;
            if (q > 128'sd2147483647) begin
                n_sat++;
                return 32'sh7FFF_FFFF;
            end
            if (q < -128'sd2147483648) begin
                n_sat++;
                return 32'sh8000_0000;
            end
            return q[31:0];
        endfunction

        function void note_item(t_coord v[4][3]);
            logic signed [127:0] m[3][3];
            logic signed [127:0] cf[3][3];
            logic signed [127:0] det;
            logic [127:0]        dbits;
            t_row_exp            e;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    m[r][c] = 128'(v[c+1][r]) - 128'(v[0][r]);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    cf[r][c] = m[(r+1)%3][(c+1)%3] * m[(r+2)%3][(c+2)%3]
                             - m[(r+1)%3][(c+2)%3] * m[(r+2)%3][(c+1)%3];
            det = m[0][0]*cf[0][0] + m[0][1]*cf[0][1] + m[0][2]*cf[0][2];
            dbits = det >>> 27;
            if (det == 0) n_sing++;
            for (int r = 0; r < 3; r++) begin
                e.row  = r[1:0];
                e.sing = (det == 0);
                e.last = (r == 2);
                e.jac  = dbits[48:0];
                e.c0   = e.sing ? 32'sd0 : entry(cf[r][0], det);
                e.c1   = e.sing ? 32'sd0 : entry(cf[r][1], det);
                e.c2   = e.sing ? 32'sd0 : entry(cf[r][2], det);
                rows_q.push_back(e);
            end
        endfunction

        function void check_row(t_row_exp a);
            t_row_exp e;
            n_rows++;
            if (rows_q.size() == 0) begin
                $display("%0t: unexpected row %0d", $time, a.row);
                errors++;
                return;
            end
            e = rows_q.pop_front();
            if (a.row !== e.row) begin
                $display("%0t: row_index exp %0d got %0d", $time, e.row, a.row);
                errors++;
            end
            if (a.c0 !== e.c0) begin
                $display("%0t: inv_c0 exp %0d got %0d", $time, e.c0, a.c0);
                errors++;
            end
            if (a.c1 !== e.c1) begin
                $display("%0t: inv_c1 exp %0d got %0d", $time, e.c1, a.c1);
                errors++;
            end
            if (a.c2 !== e.c2) begin
                $display("%0t: inv_c2 exp %0d got %0d", $time, e.c2, a.c2);
                errors++;
            end
            if (a.jac !== e.jac) begin
                $display("%0t: jacobian exp %0d got %0d", $time, e.jac, a.jac);
                errors++;
            end
            if (a.sing !== e.sing) begin
                $display("%0t: singular exp %0b got %0b", $time, e.sing, a.sing);
                errors++;
            end
            if (a.last !== e.last) begin
                $display("%0t: last exp %0b got %0b", $time, e.last, a.last);
                errors++;
            end
        endfunction
    endclass

    localparam int CycleLimit = 400000;

    logic i_clk;
    logic i_rst_n;

    tami_item_if item_ch();
    tami_row_if  row_ch();

    tetra_affine_map_inverse i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_row   (row_ch.source)
    );

    inverse_board board;
    int  send_idle_pct;   // chance in percent that the sender idles a cycle
    int  recv_idle_pct;   // chance in percent that the receiver stalls a cycle
    bit  hold_off;        // long receiver hold-off for the pressure phase
    int  cycles;
    int  n_items;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("timeout after %0d cycles", cycles);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Receiver: random ready, checks every accepted output transaction.
    initial begin
        t_row_exp got;
        row_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && row_ch.valid && row_ch.ready) begin
                got.row  = row_ch.row_index;
                got.c0   = row_ch.inv_c0;
                got.c1   = row_ch.inv_c1;
                got.c2   = row_ch.inv_c2;
                got.jac  = row_ch.jacobian;
                got.sing = row_ch.singular;
                got.last = row_ch.last;
                board.check_row(got);
            end
            row_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_coord rnd_coord(int mode);
        case (mode)
            0:       return t_coord'($urandom);
            1:       return t_coord'($urandom_range(65536 * 4) - 65536 * 2);
            default: return t_coord'($urandom_range(255) - 128);
        endcase
    endfunction

    // Offer one tetrahedron and wait until it is accepted.
    task automatic send_item(t_coord v[4][3]);
        item_ch.valid <= 1'b1;
        item_ch.v0_x <= v[0][0]; item_ch.v0_y <= v[0][1]; item_ch.v0_z <= v[0][2];
        item_ch.v1_x <= v[1][0]; item_ch.v1_y <= v[1][1]; item_ch.v1_z <= v[1][2];
        item_ch.v2_x <= v[2][0]; item_ch.v2_y <= v[2][1]; item_ch.v2_z <= v[2][2];
        item_ch.v3_x <= v[3][0]; item_ch.v3_y <= v[3][1]; item_ch.v3_z <= v[3][2];
        do @(posedge i_clk); while (!item_ch.ready);
        board.note_item(v);
        n_items++;
        // idle gap; valid stays high when the next item follows at once
        if ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int count);
        t_coord v[4][3];
        int     mode;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(2);
            for (int p = 0; p < 4; p++)
                for (int a = 0; a < 3; a++)
                    v[p][a] = rnd_coord(mode);
            // some degenerate shapes: coplanar or repeated vertices
            case ($urandom_range(9))
                0: v[3] = v[1];
                1: for (int a = 0; a < 3; a++) v[3][a] = v[0][a];
                2: for (int a = 0; a < 3; a++) v[2][a] = v[0][a] + (v[1][a] - v[0][a]);
                default: ;
            endcase
            send_item(v);
        end
    endtask

    function automatic int p_idx(int k);
        return k % 4;
    endfunction

    task automatic send_directed();
        t_coord v[4][3];
        t_coord s;
        // unit tetrahedron, scaled 2 so the map is the identity
        v = '{'{0, 0, 0}, '{24'sh20000, 0, 0}, '{0, 24'sh20000, 0}, '{0, 0, 24'sh20000}};
        send_item(v);
        // reflected: negative determinant
        v = '{'{0, 0, 0}, '{0, 24'sh20000, 0}, '{24'sh20000, 0, 0}, '{0, 0, 24'sh20000}};
        send_item(v);
        // all vertices equal: singular
        v = '{'{24'sh123456, 5, 7}, '{24'sh123456, 5, 7},
              '{24'sh123456, 5, 7}, '{24'sh123456, 5, 7}};
        send_item(v);
        // extreme span: largest edges
        v = '{'{24'sh800000, 24'sh800000, 24'sh800000}, '{24'sh7FFFFF, 24'sh800000, 24'sh800000},
              '{24'sh800000, 24'sh7FFFFF, 24'sh800000}, '{24'sh800000, 24'sh800000, 24'sh7FFFFF}};
        send_item(v);
        v = '{'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, '{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF},
              '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF}, '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000}};
        send_item(v);
        // tiny edges: inverse entries saturate
        v = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
        send_item(v);
        v = '{'{0, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
        send_item(v);
        // skewed: mixed-sign saturation
        v = '{'{0, 0, 0}, '{24'sh7FFFFF, 1, 0}, '{0, 1, 0}, '{0, 0, 2}};
        send_item(v);
        // coplanar: singular with nonzero edges
        v = '{'{0, 0, 0}, '{24'sh10000, 0, 0}, '{0, 24'sh10000, 0}, '{24'sh10000, 24'sh10000, 0}};
        send_item(v);
        // all-ones and alternating bit patterns
        for (int k = 0; k < 6; k++) begin
            s = (k % 2) ? 24'shAAAAAA : 24'sh555555;
            for (int p = 0; p < 4; p++)
                for (int a = 0; a < 3; a++)
                    v[p][a] = ((p + a + k) % 3 == 0) ? s : ~s;
            v[p_idx(k)][k % 3] = -1;
            send_item(v);
        end
    endtask

    task automatic drain();
        while (board.rows_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        n_items = 0;
        hold_off = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 68;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        {item_ch.v0_x, item_ch.v0_y, item_ch.v0_z} = '0;
        {item_ch.v1_x, item_ch.v1_y, item_ch.v1_z} = '0;
        {item_ch.v2_x, item_ch.v2_y, item_ch.v2_z} = '0;
        {item_ch.v3_x, item_ch.v3_y, item_ch.v3_z} = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        send_random(110);

        send_idle_pct = 68;
        recv_idle_pct = 18;
        send_random(110);

        // pressure: receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(20);
        join

        send_random(125);
        item_ch.valid <= 1'b0;
        drain();

        $display("%0d tetrahedra sent, %0d rows checked", n_items, board.n_rows);
        $display("%0d singular shapes, %0d saturated entries", board.n_sing, board.n_sat);
        if (board.errors == 0 && board.rows_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
